// ----- src/twva_pkg.sv -----
// ----------------------------------------------------------------------------
// twva_pkg: shared types and constants of the velocity averager
// Holds field widths, the controller state type and the command and status
// structs that pass between controller and datapath.
// ----------------------------------------------------------------------------
package twva_pkg;

	localparam int STAMP_W       = 63;
	localparam int VEL_W         = 32;
	localparam int WIN_W         = 40;
	localparam int CNT_OUT_W     = 7;
	localparam int NUM_CH        = 6;
	localparam int DEPTH_DEFAULT = 64;
	localparam logic [WIN_W-1:0] WIN_RESET = 40'd300000000;

	// register byte addresses (register index times eight, 64-bit registers)
	localparam logic [2:0] ADDR_WINDOW = 3'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EVICT,
		ST_APPEND,
		ST_DIVIDE,
		ST_DONE
	} twva_state_t;

	typedef struct packed {
		logic load;       // capture the input item
		logic rd_head;    // read the oldest stored entry
		logic evict;      // subtract the oldest entry, advance head
		logic ovf_set;    // mark an overflow eviction
		logic append;     // write new entry, add it to the sums
		logic div_start;  // begin the divider run
		logic out_load;   // move the results to the output register
	} twva_cmd_t;

	typedef struct packed {
		logic fill_zero;  // store is empty
		logic fill_full;  // store is full
		logic too_old;    // oldest entry lies outside the window
		logic div_done;   // divider has finished all channels
	} twva_sts_t;

endpackage

// ----- src/twva_if.sv -----
// ----------------------------------------------------------------------------
// twva_if: valid/ready channel carrying a generic payload
// Used for both the sample input and the result output.
// ----------------------------------------------------------------------------
interface twva_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/twva_ctrl.sv -----
// ----------------------------------------------------------------------------
// twva_ctrl: sequencing state machine
// Walks eviction, overflow drop, append, division and result hand-off.
// ----------------------------------------------------------------------------
module twva_ctrl
	import twva_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      out_busy,
	input  twva_sts_t sts,
	output twva_cmd_t cmd
);

	twva_state_t state_q, state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_CHECK;
			end
			ST_CHECK: begin
				// head entry was read last cycle; decide on eviction
				if (!sts.fill_zero && sts.too_old) state_next = ST_EVICT;
				else state_next = ST_APPEND;
			end
			ST_EVICT:  state_next = ST_CHECK;
			ST_APPEND: state_next = ST_DIVIDE;
			ST_DIVIDE: begin
				if (sts.div_done) state_next = ST_DONE;
			end
			ST_DONE: begin
				if (!out_busy) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load    = in_valid;
				cmd.rd_head = in_valid;
			end
			ST_CHECK: begin
				if (!sts.fill_zero && sts.too_old) begin
					cmd.evict = 1'b1;
				end else if (sts.fill_full) begin
					cmd.evict   = 1'b1;
					cmd.ovf_set = 1'b1;
				end
			end
			ST_EVICT: cmd.rd_head = 1'b1;
			ST_APPEND: begin
				cmd.append    = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_DIVIDE: ;
			ST_DONE: cmd.out_load = !out_busy;
			default: ;
		endcase
	end

endmodule

// ----- src/twva_dp.sv -----
// ----------------------------------------------------------------------------
// twva_dp: sample store, running sums and serial divider
// The ring store is a memory with a registered read of the head entry.
// One restoring divider serves the six channels in turn, a bit a cycle.
// ----------------------------------------------------------------------------
module twva_dp
	import twva_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
)(
	input  logic                     clk,
	input  logic                     arst_n,
	input  twva_cmd_t                cmd,
	output twva_sts_t                sts,
	input  logic [WIN_W-1:0]         window_ns,
	input  logic [STAMP_W-1:0]       in_stamp,
	input  logic [NUM_CH*VEL_W-1:0]  in_vel,
	output logic [STAMP_W-1:0]       res_stamp,
	output logic [NUM_CH*VEL_W-1:0]  res_avg,
	output logic [CNT_OUT_W-1:0]     res_count,
	output logic                     res_ovf
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int SUM_W = VEL_W + CW;
	localparam int ENT_W = STAMP_W + NUM_CH * VEL_W;
	localparam int CHW   = $clog2(NUM_CH);
	localparam int BW    = $clog2(SUM_W + 1);

	logic [ENT_W-1:0]        mem [DEPTH];
	logic [ENT_W-1:0]        head_rd_q;
	logic [AW-1:0]           head_q;
	logic [CW-1:0]           fill_q;
	logic signed [SUM_W-1:0] sum_q [NUM_CH];
	logic [STAMP_W-1:0]      stamp_q;
	logic [NUM_CH*VEL_W-1:0] vel_q;
	logic                    ovf_q;
	logic [AW-1:0]           tail;
	logic [AW:0]             tail_sum;
	logic [STAMP_W-1:0]      old_stamp;
	logic [STAMP_W:0]        age;

	// divider state
	logic                    div_busy_q;
	logic [CHW-1:0]          ch_q;
	logic [BW-1:0]           bit_q;
	logic [SUM_W-1:0]        quo_q;
	logic [SUM_W-1:0]        rem_q;
	logic                    neg_q;
	logic [NUM_CH*VEL_W-1:0] avg_q;
	logic [SUM_W-1:0]        rem_sh;
	logic [SUM_W:0]          rem_try;
	logic signed [SUM_W-1:0] cur_sum;
	logic [SUM_W-1:0]        quo_fix;

	// tail address, wrapping at the depth
	assign tail_sum = {1'b0, head_q} + (AW+1)'(fill_q);
	assign tail = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
	                                           : AW'(tail_sum);

	// memory write and registered head read (head already advanced after an eviction)
	always_ff @(posedge clk) begin
		if (cmd.append) mem[tail] <= {stamp_q, vel_q};
		if (cmd.rd_head) head_rd_q <= mem[head_q];
	end

	// window compare on the oldest entry
	assign old_stamp = head_rd_q[ENT_W-1 -: STAMP_W];
	assign age = {1'b0, stamp_q} - {1'b0, old_stamp};
	assign sts.too_old   = !age[STAMP_W] && (age[STAMP_W-1:0] > {23'd0, window_ns});
	assign sts.fill_zero = (fill_q == '0);
	assign sts.fill_full = (fill_q >= CW'(DEPTH));

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stamp_q <= in_stamp;
			vel_q   <= in_vel;
		end
	end

	// ring pointers, sums and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			ovf_q  <= 1'b0;
			for (int i = 0; i < NUM_CH; i++) sum_q[i] <= '0;
		end else begin
			if (cmd.load) ovf_q <= 1'b0;
			if (cmd.ovf_set) ovf_q <= 1'b1;
			if (cmd.evict) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
				fill_q <= fill_q - 1'b1;
				for (int i = 0; i < NUM_CH; i++)
					sum_q[i] <= sum_q[i] - SUM_W'($signed(head_rd_q[i*VEL_W +: VEL_W]));
			end else if (cmd.append) begin
				fill_q <= fill_q + 1'b1;
				for (int i = 0; i < NUM_CH; i++)
					sum_q[i] <= sum_q[i] + SUM_W'($signed(vel_q[i*VEL_W +: VEL_W]));
			end
		end
	end

	// restoring divider step on magnitude
	assign cur_sum = sum_q[ch_q];
	assign rem_sh  = {rem_q[SUM_W-2:0], quo_q[SUM_W-1]};
	assign rem_try = {1'b0, rem_sh} - {{(SUM_W+1-CW){1'b0}}, fill_q};
	assign quo_fix = neg_q ? (~quo_q + 1'b1) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			ch_q       <= '0;
			bit_q      <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			ch_q       <= '0;
			bit_q      <= '0;
		end else if (div_busy_q) begin
			if (bit_q == BW'(SUM_W + 1)) begin
				bit_q <= '0;
				if (ch_q == CHW'(NUM_CH - 1)) div_busy_q <= 1'b0;
				else ch_q <= ch_q + 1'b1;
			end else begin
				bit_q <= bit_q + 1'b1;
			end
		end
	end

	// per channel: a setup step, SUM_W shift steps, then a store step
	always_ff @(posedge clk) begin
		if (div_busy_q) begin
			if (bit_q == '0) begin
				neg_q <= cur_sum[SUM_W-1];
				quo_q <= cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : cur_sum;
				rem_q <= '0;
			end else if (bit_q == BW'(SUM_W + 1)) begin
				avg_q[ch_q*VEL_W +: VEL_W] <= quo_fix[VEL_W-1:0];
			end else begin
				if (!rem_try[SUM_W]) begin
					rem_q <= rem_try[SUM_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[SUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign sts.div_done = !div_busy_q && !cmd.div_start;

	assign res_stamp = stamp_q;
	assign res_avg   = avg_q;
	assign res_count = CNT_OUT_W'(fill_q);
	assign res_ovf   = ovf_q;

endmodule

// ----- src/time_window_velocity_averager_top.sv -----
// Flow: one item at a time, averaged by the bit-serial divider shared over six channels;
//   the next item is taken once the result sits in the output register, so a waiting
//   result does not block it.
// Reset: arst_n clears pointers, sums and control; window_ns returns to 300000000.
// ----------------------------------------------------------------------------
// time_window_velocity_averager_top: windowed mean of six velocity channels
// APB register port, input and output channels, controller and datapath.
// ----------------------------------------------------------------------------
module time_window_velocity_averager_top
	import twva_pkg::*;
#(
	parameter int HISTORY_DEPTH = DEPTH_DEFAULT
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	twva_if.sink        in_ch,
	twva_if.source      out_ch
);

	twva_cmd_t cmd;
	twva_sts_t sts;
	logic [WIN_W-1:0]        window_q;
	logic                    out_valid_q;
	logic [STAMP_W-1:0]      res_stamp;
	logic [NUM_CH*VEL_W-1:0] res_avg;
	logic [CNT_OUT_W-1:0]    res_count;
	logic                    res_ovf;
	logic                    in_ready;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_WINDOW) begin
			window_q <= pwdata[WIN_W-1:0];
		end
	end
	assign prdata = (paddr == ADDR_WINDOW) ? {24'd0, window_q} : 64'd0;

	twva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.out_busy (out_valid_q && !out_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);
	assign in_ch.ready = in_ready;

	twva_dp #(.DEPTH(HISTORY_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.window_ns (window_q),
		.in_stamp  (in_ch.data.stamp_ns),
		.in_vel    ({in_ch.data.ang_z, in_ch.data.ang_y, in_ch.data.ang_x,
		              in_ch.data.lin_z, in_ch.data.lin_y, in_ch.data.lin_x}),
		.res_stamp (res_stamp),
		.res_avg   (res_avg),
		.res_count (res_count),
		.res_ovf   (res_ovf)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_ch.data.out_stamp_ns <= res_stamp;
			out_ch.data.avg_lin_x    <= res_avg[0*VEL_W +: VEL_W];
			out_ch.data.avg_lin_y    <= res_avg[1*VEL_W +: VEL_W];
			out_ch.data.avg_lin_z    <= res_avg[2*VEL_W +: VEL_W];
			out_ch.data.avg_ang_x    <= res_avg[3*VEL_W +: VEL_W];
			out_ch.data.avg_ang_y    <= res_avg[4*VEL_W +: VEL_W];
			out_ch.data.avg_ang_z    <= res_avg[5*VEL_W +: VEL_W];
			out_ch.data.sample_count <= res_count;
			out_ch.data.overflowed   <= res_ovf;
		end
	end
	assign out_ch.valid = out_valid_q;

endmodule

// ----- src/twva_checker.sv -----
// ----------------------------------------------------------------------------
// twva_checker: port-level assertions of the averager
// Watches handshakes and result fields on the top level.
// ----------------------------------------------------------------------------
module twva_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] count,
	input logic       ovf
);

	// no input is taken in the cycle straight after a transfer
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("input taken twice");

	// a result never reports an empty window
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count != 7'd0) else $error("zero count");

	// a stalled result holds its count
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(count))
		else $error("result changed while stalled");

	// overflow reported only on a full window
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ovf |-> count == 7'd64) else $error("overflow with spare room");

endmodule

bind time_window_velocity_averager_top twva_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.count     (out_ch.data.sample_count),
	.ovf       (out_ch.data.overflowed)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the time-window velocity averager
// Feeds timestamped six-channel velocity samples through the input channel,
// keeps a cycle-free model of the sliding window (eviction by age, eviction
// on a full store, exact sums, truncating division) and compares every
// result transfer against it. The window register is rewritten between
// phases over zero, its maximum, small and random values.
// ----------------------------------------------------------------------------
module tb_top
	import twva_pkg::*;
();

	localparam int DEPTH = DEPTH_DEFAULT;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

	typedef struct packed {
		logic [STAMP_W-1:0] stamp_ns;
		logic [VEL_W-1:0]   lin_x;
		logic [VEL_W-1:0]   lin_y;
		logic [VEL_W-1:0]   lin_z;
		logic [VEL_W-1:0]   ang_x;
		logic [VEL_W-1:0]   ang_y;
		logic [VEL_W-1:0]   ang_z;
	} sample_t;

	typedef struct packed {
		logic [STAMP_W-1:0]   out_stamp_ns;
		logic [VEL_W-1:0]     avg_lin_x;
		logic [VEL_W-1:0]     avg_lin_y;
		logic [VEL_W-1:0]     avg_lin_z;
		logic [VEL_W-1:0]     avg_ang_x;
		logic [VEL_W-1:0]     avg_ang_y;
		logic [VEL_W-1:0]     avg_ang_z;
		logic [CNT_OUT_W-1:0] sample_count;
		logic                 overflowed;
	} mean_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	twva_if #(.payload_t(sample_t)) in_ch ();
	twva_if #(.payload_t(mean_t))   out_ch ();

	time_window_velocity_averager_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	sample_t pending_samples[$];
	mean_t   expected_means[$];
	int      failures;
	int      sent_count;
	int      recv_count;
	longint  cycle_count;

	// window model state
	logic [STAMP_W-1:0] win_stamp[DEPTH];
	longint             win_vel[DEPTH][NUM_CH];
	longint             win_sum[NUM_CH];
	int                 win_head;
	int                 win_fill;
	logic [WIN_W-1:0]   win_len;

	// stimulus stamp cursor
	logic [STAMP_W-1:0] stamp_cursor;

	function automatic void drop_oldest_sample();
		for (int i = 0; i < NUM_CH; i++)
			win_sum[i] -= win_vel[win_head][i];
		win_head = (win_head + 1) % DEPTH;
		win_fill--;
	endfunction

	// evict by age, then by capacity, append, and form the means
	function automatic mean_t window_mean(sample_t s);
		mean_t              r;
		logic [STAMP_W-1:0] oldest;
		logic               ovf;
		int                 slot;
		logic [VEL_W-1:0]   vin[NUM_CH];
		longint             q[NUM_CH];
		vin = '{s.lin_x, s.lin_y, s.lin_z, s.ang_x, s.ang_y, s.ang_z};
		ovf = 1'b0;
		while (win_fill > 0) begin
			oldest = win_stamp[win_head];
			if (s.stamp_ns >= oldest && (s.stamp_ns - oldest) > {23'd0, win_len})
				drop_oldest_sample();
			else
				break;
		end
		if (win_fill >= DEPTH) begin
			drop_oldest_sample();
			ovf = 1'b1;
		end
		slot = (win_head + win_fill) % DEPTH;
		win_stamp[slot] = s.stamp_ns;
		for (int i = 0; i < NUM_CH; i++) begin
			win_vel[slot][i] = longint'(signed'(vin[i]));
			win_sum[i] += win_vel[slot][i];
		end
		win_fill++;
		for (int i = 0; i < NUM_CH; i++)
			q[i] = win_sum[i] / longint'(win_fill);
		r.out_stamp_ns = s.stamp_ns;
		r.avg_lin_x    = q[0][VEL_W-1:0];
		r.avg_lin_y    = q[1][VEL_W-1:0];
		r.avg_lin_z    = q[2][VEL_W-1:0];
		r.avg_ang_x    = q[3][VEL_W-1:0];
		r.avg_ang_y    = q[4][VEL_W-1:0];
		r.avg_ang_z    = q[5][VEL_W-1:0];
		r.sample_count = win_fill[CNT_OUT_W-1:0];
		r.overflowed   = ovf;
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// input driver: random gaps, with a quiet stretch of back-to-back offers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_means = {expected_means, window_mean(in_ch.data)};
				sent_count <= sent_count + 1;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_samples.size() > 0 &&
				    ((sent_count > 300 && sent_count < 520) ||
				     $urandom_range(0, 99) >= 22)) begin
					in_ch.data  <= pending_samples[0];
					in_ch.valid <= 1'b1;
					pending_samples.delete(0);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: random stalls, field-by-field compare
	always @(posedge clk or negedge arst_n) begin
		mean_t exp_r;
		mean_t got;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				recv_count <= recv_count + 1;
				if (expected_means.size() == 0) begin
					$error("unexpected result transfer, stamp %0d", got.out_stamp_ns);
					failures++;
				end else begin
					exp_r = expected_means[0];
					expected_means.delete(0);
					if (got.out_stamp_ns !== exp_r.out_stamp_ns) begin
						$error("out_stamp_ns exp %0d got %0d", exp_r.out_stamp_ns,
						       got.out_stamp_ns);
						failures++;
					end
					if (got.avg_lin_x !== exp_r.avg_lin_x) begin
						$error("avg_lin_x exp %h got %h", exp_r.avg_lin_x, got.avg_lin_x);
						failures++;
					end
					if (got.avg_lin_y !== exp_r.avg_lin_y) begin
						$error("avg_lin_y exp %h got %h", exp_r.avg_lin_y, got.avg_lin_y);
						failures++;
					end
					if (got.avg_lin_z !== exp_r.avg_lin_z) begin
						$error("avg_lin_z exp %h got %h", exp_r.avg_lin_z, got.avg_lin_z);
						failures++;
					end
					if (got.avg_ang_x !== exp_r.avg_ang_x) begin
						$error("avg_ang_x exp %h got %h", exp_r.avg_ang_x, got.avg_ang_x);
						failures++;
					end
					if (got.avg_ang_y !== exp_r.avg_ang_y) begin
						$error("avg_ang_y exp %h got %h", exp_r.avg_ang_y, got.avg_ang_y);
						failures++;
					end
					if (got.avg_ang_z !== exp_r.avg_ang_z) begin
						$error("avg_ang_z exp %h got %h", exp_r.avg_ang_z, got.avg_ang_z);
						failures++;
					end
					if (got.sample_count !== exp_r.sample_count) begin
						$error("sample_count exp %0d got %0d", exp_r.sample_count,
						       got.sample_count);
						failures++;
					end
					if (got.overflowed !== exp_r.overflowed) begin
						$error("overflowed exp %b got %b", exp_r.overflowed, got.overflowed);
						failures++;
					end
				end
			end
			out_ch.ready <= (recv_count > 700 && recv_count < 900) ||
			                ($urandom_range(0, 99) >= 22);
		end
	end

	// register write: setup then access cycle
	task automatic write_window(input logic [WIN_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_WINDOW;
		pwdata  <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		win_len = value;
	endtask

	function automatic logic [VEL_W-1:0] rand_vel();
		case ($urandom_range(0, 9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic void queue_sample(input logic [STAMP_W-1:0] st,
	                                     input logic [VEL_W-1:0] v);
		sample_t s;
		s.stamp_ns = st;
		s.lin_x = (v === 'x) ? rand_vel() : v;
		s.lin_y = rand_vel();
		s.lin_z = rand_vel();
		s.ang_x = rand_vel();
		s.ang_y = rand_vel();
		s.ang_z = rand_vel();
		pending_samples = {pending_samples, s};
	endfunction

	function automatic void queue_all_vel(input logic [STAMP_W-1:0] st,
	                                      input logic [VEL_W-1:0] v);
		sample_t s;
		s = '{st, v, v, v, v, v, v};
		pending_samples = {pending_samples, s};
	endfunction

	// random run: mostly advancing stamps, a few steps back and wild stamps
	function automatic void queue_run(input int n, input longint unsigned step_max);
		longint unsigned step;
		for (int k = 0; k < n; k++) begin
			step = {$urandom, $urandom} % (step_max + 1);
			case ($urandom_range(0, 99))
				0, 1, 2: stamp_cursor = stamp_cursor - step[STAMP_W-1:0];
				3:       stamp_cursor = STAMP_W'({$urandom, $urandom});
				default: begin
					if (stamp_cursor > STAMP_MAX - step[STAMP_W-1:0])
						stamp_cursor = step[STAMP_W-1:0];
					else
						stamp_cursor = stamp_cursor + step[STAMP_W-1:0];
				end
			endcase
			queue_sample(stamp_cursor, 'x);
		end
	endfunction

	task automatic drain();
		wait (pending_samples.size() == 0 && expected_means.size() == 0 && !in_ch.valid);
		repeat (300) @(posedge clk);
	endtask

	initial begin
		logic [WIN_W-1:0] rnd_win;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		failures = 0;
		sent_count = 0;
		recv_count = 0;
		cycle_count = 0;
		win_head = 0;
		win_fill = 0;
		win_len = WIN_RESET;
		stamp_cursor = '0;
		for (int i = 0; i < NUM_CH; i++)
			win_sum[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset window, extremes, edge of window, stamp going back
		queue_all_vel(63'd0, 32'h7FFF_FFFF);
		queue_all_vel(63'd0, 32'h7FFF_FFFF);
		queue_all_vel(63'd0, 32'h8000_0000);
		queue_all_vel(63'd10, 32'hFFFF_FFFF);
		queue_all_vel(63'd300000000, 32'h0000_0001);
		queue_all_vel(63'd300000001, 32'h8000_0000);
		queue_sample(63'd5, 'x);
		queue_sample(63'd300000010, 'x);
		queue_all_vel(STAMP_MAX, 32'h7FFF_FFFF);
		queue_all_vel(STAMP_MAX, 32'h8000_0000);
		queue_sample(63'd1, 'x);
		drain();

		// zero window: only entries with equal or later stamps survive
		write_window('0);
		stamp_cursor = 63'd1000;
		queue_sample(stamp_cursor, 'x);
		queue_sample(stamp_cursor, 'x);
		queue_sample(stamp_cursor, 'x);
		queue_sample(stamp_cursor + 1, 'x);
		queue_run(200, 1);
		drain();

		// widest window: the store fills and overflows, high stamp bits move
		write_window({WIN_W{1'b1}});
		stamp_cursor = STAMP_W'({$urandom, $urandom});
		queue_run(500, 64'hFFFF_FFFF);
		drain();

		// short window: steady partial eviction
		write_window(40'd1000);
		stamp_cursor = 63'd5000;
		queue_run(500, 400);
		drain();

		// random window
		rnd_win = WIN_W'({$urandom, $urandom});
		write_window(rnd_win);
		queue_run(400, (rnd_win >> 3) + 1);
		drain();

		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
src/twva_pkg.sv
src/twva_if.sv
src/twva_ctrl.sv
src/twva_dp.sv
src/time_window_velocity_averager_top.sv
src/twva_checker.sv
test/tb_top.sv
